### rtl/core/pte_pkg.sv
// Shared types and codes for the Patricia trie engine.
// Holds the command and result word layouts, status codes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package pte_pkg;

  // Parameter defaults
  localparam int unsigned KEY_BITS_DEF = 8;
  localparam int unsigned NODES_DEF    = 256;

  // Seed of the header key; its low key bits form the header key
  localparam int unsigned HEADER_SEED  = 99999;

  // Command codes
  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_SENTINEL = 3'd4;

  // Command word
  typedef struct packed {
    logic       op;
    logic [7:0] key;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] node_index;
    logic [2:0] split_bit;
  } res_t;

endpackage

### rtl/core/patricia_trie_engine.sv
// Patricia trie engine: search and insert over a node store held in one RAM.
// Depends on pte_pkg for the command/result words and status codes.
//
//   Channel   Direction  Handshake              Word
//   command   in         start & !busy          cmd_i  (op, key)
//   result    out        done_o, one cycle      res_o  (status, node_index, split_bit)
//
// Each node visit issues the read of the next node on the edge that registers
// the current link, so the store's single read port sets the pace. A search
// runs a descent and a decision; an insert runs two descents with the decision
// between them, then one or two writes: the new node, and the parent's link
// unless the new node becomes the root.
// busy stays high from acceptance until the edge that raises done_o.
// Reset clears the root link and the node count; the store needs no clearing
// pass since only written slots are ever linked. Results cannot be stalled.
`timescale 1ns / 1ps

module patricia_trie_engine #(
  parameter int unsigned KEY_BITS = pte_pkg::KEY_BITS_DEF,
  parameter int unsigned NODES    = pte_pkg::NODES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  pte_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          done_o,
  output pte_pkg::res_t res_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned BW = $clog2(KEY_BITS);

  localparam logic [LW-1:0]       HDR_LINK = LW'(NODES);
  localparam logic [KEY_BITS-1:0] HDR_KEY  = KEY_BITS'(pte_pkg::HEADER_SEED);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_D1   = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_D2   = 3'd3;
  localparam logic [2:0] S_WN   = 3'd4;
  localparam logic [2:0] S_WP   = 3'd5;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [BW-1:0]       bit_idx;
    logic [LW-1:0]       left;
    logic [LW-1:0]       right;
  } node_t;

  // Key bit at a trie bit index, index 0 being the MSB
  function automatic logic kbit(input logic [KEY_BITS-1:0] k, input logic [BW-1:0] idx);
    logic [BW-1:0] pos;
    pos = BW'(KEY_BITS - 1) - idx;
    return k[pos];
  endfunction

  // First differing bit, MSB first; last bit when the upper bits agree
  function automatic logic [BW-1:0] first_diff(input logic [KEY_BITS-1:0] d);
    logic [BW-1:0] r;
    r = BW'(KEY_BITS - 1);
    for (int j = KEY_BITS - 2; j >= 0; j--) begin
      if (d[KEY_BITS-1-j]) r = BW'(j);
    end
    return r;
  endfunction

  logic [2:0]          state_q, state_d;
  logic                op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [LW-1:0]       cur_q, cur_d;
  logic                prev_v_q, prev_v_d;
  logic [BW-1:0]       prev_q, prev_d;
  logic                hit_hdr_q, hit_hdr_d;
  logic [AW-1:0]       hit_idx_q, hit_idx_d;
  logic [KEY_BITS-1:0] hit_key_q, hit_key_d;
  logic [BW-1:0]       hit_bit_q, hit_bit_d;
  logic [BW-1:0]       sb_q, sb_d;
  logic                par_hdr_q, par_hdr_d;
  logic [AW-1:0]       par_idx_q, par_idx_d;
  node_t               par_ent_q, par_ent_d;
  logic [LW-1:0]       hll_q, hll_d;
  logic [CW-1:0]       count_q, count_d;
  logic                done_q, done_d;
  pte_pkg::res_t       res_q, res_d;

  // Node store
  node_t         mem [NODES];
  node_t         rd_q;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  node_t         wd;

  logic          cur_hdr;
  logic          key_match;
  logic [AW-1:0] slot;
  logic [LW-1:0] slot_link;

  assign cur_hdr   = (cur_q >= HDR_LINK);
  assign key_match = !hit_hdr_q && (key_q == hit_key_q);
  assign slot      = count_q[AW-1:0];
  assign slot_link = LW'(slot);
  assign rd_addr   = cur_d[AW-1:0];

  // Read the node that the next link points to
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
  end

  // Write one node per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Sequencer: descend and decide; an insert then descends again and writes
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    cur_d     = cur_q;
    prev_v_d  = prev_v_q;
    prev_d    = prev_q;
    hit_hdr_d = hit_hdr_q;
    hit_idx_d = hit_idx_q;
    hit_key_d = hit_key_q;
    hit_bit_d = hit_bit_q;
    sb_d      = sb_q;
    par_hdr_d = par_hdr_q;
    par_idx_d = par_idx_q;
    par_ent_d = par_ent_q;
    hll_d     = hll_q;
    count_d   = count_q;
    done_d    = 1'b0;
    res_d     = res_q;
    we        = 1'b0;
    wa        = slot;
    wd        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = cmd_i.op;
          key_d    = KEY_BITS'(cmd_i.key);
          cur_d    = hll_q;
          prev_v_d = 1'b0;
          state_d  = S_D1;
        end
      end

      // First descent: stop once the bit index stops increasing
      S_D1: begin
        if (cur_hdr || (prev_v_q && rd_q.bit_idx <= prev_q)) begin
          hit_hdr_d = cur_hdr;
          hit_idx_d = cur_q[AW-1:0];
          hit_key_d = cur_hdr ? HDR_KEY : rd_q.key;
          hit_bit_d = rd_q.bit_idx;
          state_d   = S_DEC;
        end else begin
          prev_v_d = 1'b1;
          prev_d   = rd_q.bit_idx;
          cur_d    = kbit(key_q, rd_q.bit_idx) ? rd_q.right : rd_q.left;
        end
      end

      // Report a search or a rejected insert, else start the second descent
      S_DEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        res_d   = '{status: pte_pkg::ST_OK, node_index: '0, split_bit: '0};
        if (op_q == pte_pkg::OP_SEARCH) begin
          if (key_match) begin
            res_d.node_index = 8'(hit_idx_q);
            res_d.split_bit  = 3'(hit_bit_q);
          end else begin
            res_d.status = pte_pkg::ST_NOTFOUND;
          end
        end else begin
          priority if (key_match) begin
            res_d.status = pte_pkg::ST_DUP;
          end else if (hit_hdr_q && key_q == HDR_KEY) begin
            res_d.status = pte_pkg::ST_SENTINEL;
          end else if (count_q >= CW'(NODES)) begin
            res_d.status = pte_pkg::ST_FULL;
          end else begin
            done_d    = 1'b0;
            sb_d      = first_diff(key_q ^ hit_key_q);
            par_hdr_d = 1'b1;
            cur_d     = hll_q;
            state_d   = S_D2;
          end
        end
      end

      // Second descent: stop where the new node belongs
      S_D2: begin
        if (cur_hdr || rd_q.bit_idx >= sb_q ||
            (!par_hdr_q && rd_q.bit_idx <= par_ent_q.bit_idx)) begin
          state_d = S_WN;
        end else begin
          par_hdr_d = 1'b0;
          par_idx_d = cur_q[AW-1:0];
          par_ent_d = rd_q;
          cur_d     = kbit(key_q, rd_q.bit_idx) ? rd_q.right : rd_q.left;
        end
      end

      // Write the new node; relink the root here or the parent next cycle
      S_WN: begin
        we         = 1'b1;
        wa         = slot;
        wd.key     = key_q;
        wd.bit_idx = sb_q;
        if (kbit(key_q, sb_q)) begin
          wd.left  = cur_q;
          wd.right = slot_link;
        end else begin
          wd.left  = slot_link;
          wd.right = cur_q;
        end
        if (par_hdr_q) begin
          hll_d   = slot_link;
          count_d = count_q + CW'(1);
          done_d  = 1'b1;
          res_d   = '{status: pte_pkg::ST_OK, node_index: 8'(slot), split_bit: 3'(sb_q)};
          state_d = S_IDLE;
        end else begin
          state_d = S_WP;
        end
      end

      S_WP: begin
        we = 1'b1;
        wa = par_idx_q;
        wd = par_ent_q;
        if (kbit(key_q, par_ent_q.bit_idx)) begin
          wd.right = slot_link;
        end else begin
          wd.left = slot_link;
        end
        count_d = count_q + CW'(1);
        done_d  = 1'b1;
        res_d   = '{status: pte_pkg::ST_OK, node_index: 8'(slot), split_bit: 3'(sb_q)};
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hll_q   <= HDR_LINK;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hll_q   <= hll_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    cur_q     <= cur_d;
    prev_v_q  <= prev_v_d;
    prev_q    <= prev_d;
    hit_hdr_q <= hit_hdr_d;
    hit_idx_q <= hit_idx_d;
    hit_key_q <= hit_key_d;
    hit_bit_q <= hit_bit_d;
    sb_q      <= sb_d;
    par_hdr_q <= par_hdr_d;
    par_idx_q <= par_idx_d;
    par_ent_q <= par_ent_d;
    res_q     <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // A result word only follows a command in flight
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a command in flight");

  // The fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NODES))
    else $error("node count beyond store depth");

  // A successful insert takes exactly one new slot
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q == pte_pkg::OP_INSERT && res_o.status == pte_pkg::ST_OK)
      |-> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not advance the node count");

  // Anything but a successful insert leaves the root link alone
  a_root_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !(op_q == pte_pkg::OP_INSERT && res_o.status == pte_pkg::ST_OK))
      |-> $stable(hll_q))
    else $error("root link changed without an insert");

endmodule

### test/tb.sv
// Self-checking bench for patricia_trie_engine: directed, random and exhaustive words vs a trie predictor.
// Depends on pte_pkg (command/result words, status codes) and the engine RTL.
`timescale 1ns / 1ps

module tb;

  localparam int KEY_BITS    = pte_pkg::KEY_BITS_DEF;
  localparam int NODES       = pte_pkg::NODES_DEF;
  localparam logic [7:0] HEADER_KEY = 8'(pte_pkg::HEADER_SEED);
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 620;
  localparam int MAX_REPORTS = 100;

  // Trie predictor plus queue of results still owed by the engine
  class pte_scoreboard;
    logic [7:0] node_key [NODES];
    int node_bit [NODES];
    int node_left [NODES];
    int node_right [NODES];
    int root_link;
    int node_count;
    pte_pkg::res_t owed_q[$];
    int mismatches;
    int words_sent;
    int results_seen;
    int status_seen[5];

    function new();
      root_link = NODES;
      node_count = 0;
      mismatches = 0;
      words_sent = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (node_key[i]) begin
        node_key[i] = '0;
        node_bit[i] = 0;
        node_left[i] = 0;
        node_right[i] = 0;
      end
    endfunction

    // Bit 0 is the key MSB; indexes outside the key read as zero
    function bit key_bit(logic [7:0] key, int idx);
      if (idx < 0 || idx >= KEY_BITS) return 1'b0;
      return key[KEY_BITS - 1 - idx];
    endfunction

    function int link_bit(int lk);
      return (lk >= NODES) ? -1 : node_bit[lk];
    endfunction

    function logic [7:0] link_key(int lk);
      return (lk >= NODES) ? HEADER_KEY : node_key[lk];
    endfunction

    function int child(int lk, logic [7:0] key);
      if (lk >= NODES) return root_link;
      return key_bit(key, node_bit[lk]) ? node_right[lk] : node_left[lk];
    endfunction

    // Walk down until the bit index stops increasing
    function int nearest_link(logic [7:0] key);
      int cur;
      int prev;
      int b;
      cur = root_link;
      prev = -1;
      for (int s = 0; s <= KEY_BITS + 1; s++) begin
        b = link_bit(cur);
        if (b <= prev) break;
        prev = b;
        cur = child(cur, key);
      end
      return cur;
    endfunction

    // Apply one command word to the trie and return the result word it owes
    function pte_pkg::res_t apply_command(pte_pkg::cmd_t cmd);
      pte_pkg::res_t res;
      logic [7:0] key;
      int hit;
      int diff;
      int par;
      int cur;
      int cb;
      int slot;
      res = '0;
      key = cmd.key;
      hit = nearest_link(key);
      if (cmd.op == pte_pkg::OP_SEARCH) begin
        if (hit < NODES && node_key[hit] == key) begin
          res.status = pte_pkg::ST_OK;
          res.node_index = 8'(hit);
          res.split_bit = 3'(node_bit[hit]);
        end else begin
          res.status = pte_pkg::ST_NOTFOUND;
        end
        return res;
      end
      if (hit < NODES && node_key[hit] == key) begin
        res.status = pte_pkg::ST_DUP;
        return res;
      end
      if (hit >= NODES && key == HEADER_KEY) begin
        res.status = pte_pkg::ST_SENTINEL;
        return res;
      end
      if (node_count >= NODES) begin
        res.status = pte_pkg::ST_FULL;
        return res;
      end
      // first differing bit against the nearest key
      diff = 0;
      while (diff < KEY_BITS - 1 && key_bit(key, diff) == key_bit(link_key(hit), diff))
        diff++;
      // second walk: stop where the new node belongs
      par = NODES;
      cur = root_link;
      for (int s = 0; s <= KEY_BITS + 1; s++) begin
        cb = link_bit(cur);
        if (cb >= diff || cb <= link_bit(par)) break;
        par = cur;
        cur = child(cur, key);
      end
      slot = node_count;
      node_key[slot] = key;
      node_bit[slot] = diff;
      if (key_bit(key, diff)) begin
        node_left[slot] = cur;
        node_right[slot] = slot;
      end else begin
        node_left[slot] = slot;
        node_right[slot] = cur;
      end
      if (par >= NODES) root_link = slot;
      else if (key_bit(key, node_bit[par])) node_right[par] = slot;
      else node_left[par] = slot;
      node_count = slot + 1;
      res.status = pte_pkg::ST_OK;
      res.node_index = 8'(slot);
      res.split_bit = 3'(diff);
      return res;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function void note_command(pte_pkg::cmd_t cmd);
      words_sent++;
      owed_q.push_back(apply_command(cmd));
    endfunction

    task check_result(pte_pkg::res_t got);
      pte_pkg::res_t want;
      results_seen++;
      if (got.status <= pte_pkg::ST_SENTINEL) status_seen[got.status]++;
      if (owed_q.size() == 0) begin
        report($sformatf("result word %h with no command outstanding", got));
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.node_index !== want.node_index)
          report($sformatf("node_index got %0d want %0d", got.node_index, want.node_index));
        if (got.split_bit !== want.split_bit)
          report($sformatf("split_bit got %0d want %0d", got.split_bit, want.split_bit));
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  pte_pkg::cmd_t cmd_i = '0;
  logic busy;
  logic done_o;
  pte_pkg::res_t res_o;

  pte_scoreboard sb;
  int cycle_count = 0;
  int burst_left = 1;

  patricia_trie_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #4 clk_i = ~clk_i;

  // Check every result word at the edge that ends its strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Drive one command word from a falling edge, hold it until accepted, then pace the sender
  task send_command(logic op, logic [7:0] key);
    pte_pkg::cmd_t cmd;
    int gap;
    cmd.op = op;
    cmd.key = key;
    start <= 1'b1;
    cmd_i <= cmd;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_command(cmd);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 26);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    int order[NODES];
    int j;
    int tmp;
    logic op;
    logic [7:0] key;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty trie, header key, key extremes, hits, misses, duplicates
    send_command(pte_pkg::OP_SEARCH, 8'h00);
    send_command(pte_pkg::OP_SEARCH, HEADER_KEY);
    send_command(pte_pkg::OP_INSERT, HEADER_KEY);
    send_command(pte_pkg::OP_INSERT, 8'h00);
    send_command(pte_pkg::OP_INSERT, 8'hFF);
    send_command(pte_pkg::OP_INSERT, 8'h80);
    send_command(pte_pkg::OP_INSERT, 8'h7F);
    send_command(pte_pkg::OP_INSERT, 8'h01);
    send_command(pte_pkg::OP_INSERT, 8'hFE);
    send_command(pte_pkg::OP_SEARCH, 8'h00);
    send_command(pte_pkg::OP_SEARCH, 8'hFF);
    send_command(pte_pkg::OP_SEARCH, 8'h80);
    send_command(pte_pkg::OP_SEARCH, 8'h7F);
    send_command(pte_pkg::OP_SEARCH, 8'h55);
    send_command(pte_pkg::OP_INSERT, 8'h00);
    send_command(pte_pkg::OP_INSERT, 8'hFF);
    send_command(pte_pkg::OP_SEARCH, HEADER_KEY);
    send_command(pte_pkg::OP_INSERT, HEADER_KEY);
    send_command(pte_pkg::OP_SEARCH, HEADER_KEY);
    send_command(pte_pkg::OP_INSERT, 8'h9E);
    send_command(pte_pkg::OP_SEARCH, 8'h9E);

    // Random mix while the trie grows, header key favored now and then
    repeat (RANDOM_WORDS) begin
      op = ($urandom_range(0, 99) < 55) ? pte_pkg::OP_INSERT : pte_pkg::OP_SEARCH;
      key = ($urandom_range(0, 11) == 0) ? HEADER_KEY : 8'($urandom_range(0, 255));
      send_command(op, key);
    end

    // Insert every key in shuffled order, then search every key in another order
    repeat (2) begin
      foreach (order[i]) order[i] = i;
      for (int i = NODES - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      op = (sb.words_sent < RANDOM_WORDS + 21 + NODES) ? pte_pkg::OP_INSERT
                                                       : pte_pkg::OP_SEARCH;
      foreach (order[i]) send_command(op, 8'(order[i]));
    end
    start <= 1'b0;

    // Drain outstanding results, then linger for stray words
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands and %0d results: %0d ok, %0d not found, %0d duplicate,",
             sb.words_sent, sb.results_seen, sb.status_seen[pte_pkg::ST_OK],
             sb.status_seen[pte_pkg::ST_NOTFOUND], sb.status_seen[pte_pkg::ST_DUP]);
    $display("  %0d store full, %0d header key rejected; %0d nodes in trie, %0d mismatches",
             sb.status_seen[pte_pkg::ST_FULL], sb.status_seen[pte_pkg::ST_SENTINEL],
             sb.node_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
